// File: hdl/mandel_pkg.sv
// ----------------------------------------------------------------------------
// mandel_pkg
// Shared types, constants and helpers for the escape-time pixel engine.
// ----------------------------------------------------------------------------
package mandel_pkg;

  // Largest image side supported by the mirrored row arithmetic.
  localparam int MAX_SIDE_DEF = 4096;

  // Configuration register indexes.
  localparam logic [2:0] REG_REAL_START = 3'd0;
  localparam logic [2:0] REG_IMAG_START = 3'd1;
  localparam logic [2:0] REG_REAL_STEP  = 3'd2;
  localparam logic [2:0] REG_IMAG_STEP  = 3'd3;
  localparam logic [2:0] REG_ITER_LIMIT = 3'd4;
  localparam logic [2:0] REG_IMG_HEIGHT = 3'd5;

  // Register reset values (Q6.26 where fractional).
  localparam logic [31:0] REAL_START_RST = 32'hF800_0000;  // -2.0
  localparam logic [31:0] IMAG_START_RST = 32'hFA00_0000;  // -1.5
  localparam logic [25:0] REAL_STEP_RST  = 26'd196608;
  localparam logic [25:0] IMAG_STEP_RST  = 26'd196608;
  localparam logic [15:0] ITER_LIMIT_RST = 16'd256;
  localparam logic [12:0] IMG_HEIGHT_RST = 13'd1024;

  // Escape threshold: 4.0 in unsigned Q12.52.
  localparam logic [63:0] ESCAPE_MAG = 64'h0040_0000_0000_0000;

  // Saturation bounds for a 40-bit intermediate.
  localparam logic signed [39:0] SAT_MAX = 40'sh00_7FFF_FFFF;
  localparam logic signed [39:0] SAT_MIN = -40'sh00_8000_0000;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_column;
  } in_t;

  typedef struct packed {
    logic [11:0] out_row;
    logic [11:0] mirror_row;
    logic [11:0] out_column;
    logic [15:0] escape_count;
  } out_t;

  // Clamp a 40-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] res;
    if (v > SAT_MAX) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time engine: forms the point c of one pixel and iterates
// z = z*z + c with one shared signed multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                          | Payload           | Direction
//  --------+--------------------------------+-------------------+----------
//  input   | in_valid, in_stall, in_data    | pixel row, column | in
//  result  | out_valid, out_stall, out_data | rows, column, cnt | out
//  config  | cfg_we, cfg_index, cfg_data    | six registers     | in
//
// After acceptance, two multiplies (ST_C_RE, ST_C_IM) and ST_C_SET form c; a
// zero limit goes from ST_C_IM straight to the result. Each escape test then
// runs ST_SQ_RE, ST_SQ_IM, ST_CROSS and ST_UPDATE, using the multiplier for
// re*re, im*im and re*im; the number of tests is the count plus one on escape,
// else iteration_limit. The result is held until out_stall is low; in_stall
// stays high from acceptance until that result beat leaves. Reset is synchronous.
module mandelbrot_escape_time #(
  parameter int MAX_SIDE = mandel_pkg::MAX_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mandel_pkg::in_t    in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mandel_pkg::out_t   out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [11:0] SIDE_MASK = 12'(MAX_SIDE - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_RE,
    ST_C_IM,
    ST_C_SET,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // Configuration registers.
  logic [31:0] real_start_r;
  logic [31:0] imag_start_r;
  logic [25:0] real_step_r;
  logic [25:0] imag_step_r;
  logic [15:0] iter_limit_r;
  logic [12:0] img_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_start_r <= mandel_pkg::REAL_START_RST;
      imag_start_r <= mandel_pkg::IMAG_START_RST;
      real_step_r  <= mandel_pkg::REAL_STEP_RST;
      imag_step_r  <= mandel_pkg::IMAG_STEP_RST;
      iter_limit_r <= mandel_pkg::ITER_LIMIT_RST;
      img_height_r <= mandel_pkg::IMG_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mandel_pkg::REG_REAL_START: real_start_r <= cfg_data;
        mandel_pkg::REG_IMAG_START: imag_start_r <= cfg_data;
        mandel_pkg::REG_REAL_STEP:  real_step_r  <= cfg_data[25:0];
        mandel_pkg::REG_IMAG_STEP:  imag_step_r  <= cfg_data[25:0];
        mandel_pkg::REG_ITER_LIMIT: iter_limit_r <= cfg_data[15:0];
        mandel_pkg::REG_IMG_HEIGHT: img_height_r <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Datapath and sequencer registers.
  state_t                   state_r, state_nxt;
  logic [11:0]              row_r, row_nxt;
  logic [11:0]              col_r, col_nxt;
  logic signed [31:0]       cre_r, cre_nxt;
  logic signed [31:0]       cim_r, cim_nxt;
  logic signed [31:0]       zre_r, zre_nxt;
  logic signed [31:0]       zim_r, zim_nxt;
  logic signed [63:0]       prod_r, prod_nxt;
  logic signed [63:0]       r2_r, r2_nxt;
  logic signed [63:0]       i2_r, i2_nxt;
  logic signed [63:0]       diff_r, diff_nxt;
  logic [15:0]              count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  mandel_pkg::out_t         out_data_r, out_data_nxt;

  // Shared multiplier.
  logic signed [32:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [65:0]       mul_full;

  // Update-cycle terms.
  logic [63:0]              mag;
  logic                     escaped;
  logic [15:0]              count_inc;
  logic [11:0]              mirror;

  assign mul_full  = mul_a * mul_b;
  assign mag       = r2_r + i2_r;
  assign escaped   = mag > mandel_pkg::ESCAPE_MAG;
  assign count_inc = count_r + 16'd1;
  assign mirror    = (img_height_r[11:0] - 12'd1 - row_r) & SIDE_MASK;

  // Next-state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cre_nxt       = cre_r;
    cim_nxt       = cim_r;
    zre_nxt       = zre_r;
    zim_nxt       = zim_r;
    prod_nxt      = prod_r;
    r2_nxt        = r2_r;
    i2_nxt        = i2_r;
    diff_nxt      = diff_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_a         = {zre_r[31], zre_r};
    mul_b         = {zre_r[31], zre_r};

    // Result fields that do not depend on the count.
    out_data_nxt.out_row    = row_r;
    out_data_nxt.mirror_row = mirror;
    out_data_nxt.out_column = col_r;

    case (state_r)
      ST_IDLE: begin
        out_data_nxt = out_data_r;
        if (in_valid) begin
          row_nxt   = in_data.pixel_row;
          col_nxt   = in_data.pixel_column;
          count_nxt = '0;
          state_nxt = ST_C_RE;
        end
      end

      // column * real_step
      ST_C_RE: begin
        mul_a     = {21'd0, col_r};
        mul_b     = {7'd0, real_step_r};
        prod_nxt  = mul_full[63:0];
        state_nxt = ST_C_IM;
      end

      // row * imag_step, and the real part of c from the previous product.
      ST_C_IM: begin
        mul_a     = {21'd0, row_r};
        mul_b     = {7'd0, imag_step_r};
        prod_nxt  = mul_full[63:0];
        cre_nxt   = mandel_pkg::sat32({{8{real_start_r[31]}}, real_start_r}
                                      + prod_r[39:0]);
        zre_nxt   = cre_nxt;
        if (iter_limit_r == '0) begin
          out_data_nxt.escape_count = '0;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_DONE;
        end else begin
          state_nxt = ST_C_SET;
        end
      end

      // Imaginary part of c.
      ST_C_SET: begin
        cim_nxt   = mandel_pkg::sat32({{8{imag_start_r[31]}}, imag_start_r}
                                      + prod_r[39:0]);
        zim_nxt   = cim_nxt;
        state_nxt = ST_SQ_RE;
      end

      ST_SQ_RE: begin
        prod_nxt  = mul_full[63:0];
        state_nxt = ST_SQ_IM;
      end

      ST_SQ_IM: begin
        mul_a     = {zim_r[31], zim_r};
        mul_b     = {zim_r[31], zim_r};
        r2_nxt    = prod_r;
        prod_nxt  = mul_full[63:0];
        state_nxt = ST_CROSS;
      end

      ST_CROSS: begin
        mul_a     = {zre_r[31], zre_r};
        mul_b     = {zim_r[31], zim_r};
        i2_nxt    = prod_r;
        diff_nxt  = r2_r - prod_r;
        prod_nxt  = mul_full[63:0];
        state_nxt = ST_UPDATE;
      end

      // Escape test on the old z, otherwise step z and the count.
      ST_UPDATE: begin
        if (escaped) begin
          out_data_nxt.escape_count = count_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_DONE;
        end else begin
          zre_nxt   = mandel_pkg::sat32({{2{diff_r[63]}}, diff_r[63:26]}
                                        + {{8{cre_r[31]}}, cre_r});
          zim_nxt   = mandel_pkg::sat32({prod_r[63], prod_r[63:25]}
                                        + {{8{cim_r[31]}}, cim_r});
          count_nxt = count_inc;
          if (count_inc == iter_limit_r) begin
            out_data_nxt.escape_count = iter_limit_r;
            out_valid_nxt             = 1'b1;
            state_nxt                 = ST_DONE;
          end else begin
            state_nxt = ST_SQ_RE;
          end
        end
      end

      // Hold the result beat until it is taken.
      ST_DONE: begin
        out_data_nxt = out_data_r;
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = ST_IDLE;
      end
    endcase
  end

  // State, datapath and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    cre_r      <= cre_nxt;
    cim_r      <= cim_nxt;
    zre_r      <= zre_nxt;
    zim_r      <= zim_nxt;
    prod_r     <= prod_nxt;
    r2_r       <= r2_nxt;
    i2_r       <= i2_nxt;
    diff_r     <= diff_nxt;
    count_r    <= count_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/sv/tb_mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time
// Self-checking bench for the escape-time pixel engine. A short table of
// pixels covers the boundary values, a zero limit, rows past the height,
// saturated coordinates and masked or ignored register writes; then random
// views of the plane and random pixels follow, with random gaps and stalls
// on both channels and a long result stall in every fifth phase. Each accepted
// pixel beat is checked against its table row or a local fixed-point model.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CLK_HALF     = 4;
  localparam int     RESET_CYCLES = 6;
  localparam int     RANDOM_ITEMS = 650;
  localparam int     MAX_GAP      = 12;
  localparam int     LONG_HOLD    = 300;
  localparam int     IDLE_SETTLE  = 8;
  localparam longint RUN_LIMIT_NS = 60_000_000;

  // Register indexes that decode to nothing.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // Fixed-point bounds: signed Q6.26 range and 4.0 in unsigned Q12.52.
  localparam longint      Q26_MAX   = 64'sd2147483647;
  localparam longint      Q26_MIN   = -64'sd2147483648;
  localparam logic [63:0] FOUR_Q52  = 64'd4 << 52;
  // Random window of start points: real in [-2.5, -0.5], imag in [-2, 0].
  localparam int          WIN_RE_LO = -167772160;
  localparam int          WIN_IM_LO = -134217728;
  localparam int          WIN_SPAN  = 134217728;

  // Raw data words for the six registers of one view of the plane.
  typedef struct packed {
    logic [31:0] real_start;
    logic [31:0] imag_start;
    logic [31:0] real_step;
    logic [31:0] imag_step;
    logic [31:0] iter_limit;
    logic [31:0] img_height;
  } view_t;

  // One row of the directed table; want is used only when known is set.
  typedef struct packed {
    logic [2:0]       view_sel;
    mandel_pkg::in_t  px;
    logic             known;
    mandel_pkg::out_t want;
  } directed_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  mandel_pkg::in_t  in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  mandel_pkg::out_t out_data;
  logic             cfg_we    = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [31:0]      cfg_data  = '0;

  // Local copy of the register file used for prediction.
  logic signed [31:0] cur_real_start = mandel_pkg::REAL_START_RST;
  logic signed [31:0] cur_imag_start = mandel_pkg::IMAG_START_RST;
  logic [25:0]        cur_real_step  = mandel_pkg::REAL_STEP_RST;
  logic [25:0]        cur_imag_step  = mandel_pkg::IMAG_STEP_RST;
  logic [15:0]        cur_iter_limit = mandel_pkg::ITER_LIMIT_RST;
  logic [12:0]        cur_img_height = mandel_pkg::IMG_HEIGHT_RST;

  mandel_pkg::out_t pixels_in_flight[$];
  int unsigned      failures      = 0;
  bit               quiet         = 1'b0;
  bit               long_hold_req = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  mandelbrot_escape_time DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clamp a wide value to the signed 32-bit range.
  function automatic longint clamp_q26(input longint v);
    if (v > Q26_MAX) begin
      return Q26_MAX;
    end
    if (v < Q26_MIN) begin
      return Q26_MIN;
    end
    return v;
  endfunction

  // Expected result beat for one pixel under the current registers.
  function automatic mandel_pkg::out_t escape_time_of(input mandel_pkg::in_t px);
    longint           c_re, c_im, z_re, z_im, re_sq, im_sq, re_im;
    logic [63:0]      mag;
    logic [12:0]      mirror_wide;
    int unsigned      iter;
    bit               escaped;
    mandel_pkg::out_t res;
    c_re = clamp_q26(longint'(cur_real_start) +
                     longint'(px.pixel_column) * longint'(cur_real_step));
    c_im = clamp_q26(longint'(cur_imag_start) +
                     longint'(px.pixel_row) * longint'(cur_imag_step));
    z_re = c_re;
    z_im = c_im;
    iter = 0;
    escaped = 1'b0;
    // The magnitude test uses the z that the iteration starts from.
    while (!escaped && iter < cur_iter_limit) begin
      re_sq = z_re * z_re;
      im_sq = z_im * z_im;
      re_im = z_re * z_im;
      mag = re_sq + im_sq;
      if (mag > FOUR_Q52) begin
        escaped = 1'b1;
      end else begin
        z_im = clamp_q26((re_im >>> 25) + c_im);
        z_re = clamp_q26(((re_sq - im_sq) >>> 26) + c_re);
        iter++;
      end
    end
    // The mirrored row wraps modulo the 4096-row side.
    mirror_wide = cur_img_height - 13'd1 - {1'b0, px.pixel_row};
    res.out_row      = px.pixel_row;
    res.mirror_row   = mirror_wide[11:0];
    res.out_column   = px.pixel_column;
    res.escape_count = iter[15:0];
    return res;
  endfunction

  function automatic view_t make_view(input logic [31:0] rs, is, rstep, istep,
                                      input logic [31:0] lim, height);
    view_t v;
    v.real_start = rs;
    v.imag_start = is;
    v.real_step  = rstep;
    v.imag_step  = istep;
    v.iter_limit = lim;
    v.img_height = height;
    return v;
  endfunction

  function automatic directed_row_t plan_row(input int unsigned view_sel, r, c,
                                             input bit known,
                                             input int unsigned mirror, count);
    directed_row_t d;
    d.view_sel             = view_sel[2:0];
    d.px.pixel_row         = r[11:0];
    d.px.pixel_column      = c[11:0];
    d.known                = known;
    d.want.out_row         = r[11:0];
    d.want.mirror_row      = mirror[11:0];
    d.want.out_column      = c[11:0];
    d.want.escape_count    = count[15:0];
    return d;
  endfunction

  // Step size: mostly a span of 0.25 to 4 units over the full 4096-pixel side,
  // sometimes zero, the largest value or anything at all.
  function automatic logic [25:0] draw_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 26'($urandom_range(0, 26'h3FF_FFFF));
      default: return 26'($urandom_range(4096, 65536));
    endcase
  endfunction

  function automatic void check_field(input string field,
                                      input logic [15:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      failures++;
    end
  endfunction

  // One register write; the local copy keeps only the register's width.
  task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    case (index)
      mandel_pkg::REG_REAL_START: cur_real_start = data;
      mandel_pkg::REG_IMAG_START: cur_imag_start = data;
      mandel_pkg::REG_REAL_STEP:  cur_real_step  = data[25:0];
      mandel_pkg::REG_IMAG_STEP:  cur_imag_step  = data[25:0];
      mandel_pkg::REG_ITER_LIMIT: cur_iter_limit = data[15:0];
      mandel_pkg::REG_IMG_HEIGHT: cur_img_height = data[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Load a whole view, then hit the two undecoded indexes with noise.
  task automatic apply_view(input view_t v);
    write_reg(mandel_pkg::REG_REAL_START, v.real_start);
    write_reg(mandel_pkg::REG_IMAG_START, v.imag_start);
    write_reg(mandel_pkg::REG_REAL_STEP,  v.real_step);
    write_reg(mandel_pkg::REG_IMAG_STEP,  v.imag_step);
    write_reg(mandel_pkg::REG_ITER_LIMIT, v.iter_limit);
    write_reg(mandel_pkg::REG_IMG_HEIGHT, v.img_height);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one pixel beat after a random gap and queue its expected result.
  task automatic send_pixel(input mandel_pkg::in_t px, input bit known,
                            input mandel_pkg::out_t want);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    pixels_in_flight.push_back(known ? want : escape_time_of(px));
  endtask

  // Stop offering and wait until every result beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pixels_in_flight.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Result side: a random stall before each beat, or one long hold-off.
  initial begin : result_sink
    int unsigned hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    mandel_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixels_in_flight.size() == 0) begin
        $error("result beat with no pixel outstanding: row %0d column %0d",
               out_data.out_row, out_data.out_column);
        failures++;
      end else begin
        want = pixels_in_flight.pop_front();
        check_field("out_row", 16'(want.out_row), 16'(out_data.out_row));
        check_field("mirror_row", 16'(want.mirror_row), 16'(out_data.mirror_row));
        check_field("out_column", 16'(want.out_column), 16'(out_data.out_column));
        check_field("escape_count", want.escape_count, out_data.escape_count);
      end
    end
  end

  initial begin : stimulus
    directed_row_t   plan[$];
    view_t           views[6];
    view_t           rv;
    logic [2:0]      cur_view;
    mandel_pkg::in_t px;
    int unsigned     random_items;
    int unsigned     phase;
    int unsigned     burst;
    bit              pressure;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Views: reset values; zero limit and zero height; saturated corners
    // with wide data words; opposite saturation with limit and height one;
    // the origin at the largest limit; single-step zoom at the neck.
    views[0] = make_view(mandel_pkg::REAL_START_RST, mandel_pkg::IMAG_START_RST,
                         32'(mandel_pkg::REAL_STEP_RST),
                         32'(mandel_pkg::IMAG_STEP_RST),
                         32'(mandel_pkg::ITER_LIMIT_RST),
                         32'(mandel_pkg::IMG_HEIGHT_RST));
    views[1] = make_view(mandel_pkg::REAL_START_RST, mandel_pkg::IMAG_START_RST,
                         32'(mandel_pkg::REAL_STEP_RST),
                         32'(mandel_pkg::IMAG_STEP_RST), 32'd0, 32'd0);
    views[2] = make_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                         32'hFC00_0000, 32'h0001_FFFF, 32'hE000_1000);
    views[3] = make_view(32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
                         32'h03FF_FFFF, 32'd1, 32'd1);
    views[4] = make_view(32'd0, 32'd0, 32'd0, 32'd0, 32'h0000_FFFF, 32'd4096);
    views[5] = make_view(32'hFD00_0000, 32'd0, 32'd1, 32'd1, 32'd300, 32'd2000);

    //                  view  row   col   known mirror count
    plan.push_back(plan_row(0,    0,    0, 1,   1023,     0));
    plan.push_back(plan_row(0, 4095, 4095, 1,   1024,     0));
    plan.push_back(plan_row(0,  512,  512, 1,    511,   256));
    plan.push_back(plan_row(0,  512,    0, 1,    511,   256));
    plan.push_back(plan_row(0,  100,  300, 0,      0,     0));
    plan.push_back(plan_row(0,  700,  200, 0,      0,     0));
    plan.push_back(plan_row(1,    0,    0, 1,   4095,     0));
    plan.push_back(plan_row(1,  512,  512, 1,   3583,     0));
    plan.push_back(plan_row(1, 4095, 4095, 1,      0,     0));
    plan.push_back(plan_row(2,    0,    0, 1,   4095,     0));
    plan.push_back(plan_row(2, 4095, 4095, 1,      0,     0));
    plan.push_back(plan_row(2, 1234,   17, 0,      0,     0));
    plan.push_back(plan_row(3, 4095,    0, 1,      1,     0));
    plan.push_back(plan_row(3,    0, 4095, 1,      0,     0));
    plan.push_back(plan_row(4,    0,    0, 1,   4095, 65535));
    plan.push_back(plan_row(5,    0,    0, 0,      0,     0));
    plan.push_back(plan_row(5,  100, 4095, 0,      0,     0));
    plan.push_back(plan_row(5, 2047, 2048, 0,      0,     0));

    // Directed table; registers change only once the engine is empty.
    cur_view = 3'd0;
    foreach (plan[i]) begin
      if (plan[i].view_sel != cur_view) begin
        drain_results();
        apply_view(views[plan[i].view_sel]);
        cur_view = plan[i].view_sel;
      end
      send_pixel(plan[i].px, plan[i].known, plan[i].want);
    end
    drain_results();

    // Random views and pixels, phase by phase.
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      rv.real_start = ($urandom_range(0, 7) == 0) ? $urandom :
                      32'(WIN_RE_LO + int'($urandom_range(0, WIN_SPAN)));
      rv.imag_start = ($urandom_range(0, 7) == 0) ? $urandom :
                      32'(WIN_IM_LO + int'($urandom_range(0, WIN_SPAN)));
      // Bits above each register's width carry noise.
      rv.real_step = $urandom;
      rv.real_step[25:0] = draw_step();
      rv.imag_step = $urandom;
      rv.imag_step[25:0] = draw_step();
      rv.iter_limit = $urandom;
      case ($urandom_range(0, 15))
        0:       rv.iter_limit[15:0] = '0;
        1, 2:    rv.iter_limit[15:0] = 16'($urandom_range(200, 300));
        default: rv.iter_limit[15:0] = 16'($urandom_range(1, 48));
      endcase
      rv.img_height = $urandom;
      rv.img_height[12:0] = ($urandom_range(0, 7) == 0) ?
                            13'($urandom_range(0, 8191)) :
                            13'($urandom_range(1, 4096));
      apply_view(rv);

      // Some phases run with no gaps; one in five holds results back long
      // enough for the engine to back up into its input.
      pressure = (phase % 5 == 2);
      quiet = pressure || ($urandom_range(0, 3) == 0);
      if (pressure) begin
        long_hold_req = 1'b1;
      end
      burst = $urandom_range(15, 45);
      repeat (burst) begin
        px.pixel_row    = 12'($urandom_range(0, 4095));
        px.pixel_column = 12'($urandom_range(0, 4095));
        send_pixel(px, 1'b0, '0);
      end
      random_items += burst;
      drain_results();
      phase++;
    end

    repeat (2 * IDLE_SETTLE) @(posedge clk);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop in case a beat never arrives.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
